### design/sdts_pkg.sv
// ----------------------------------------------------------------------------
// sdts_pkg: shared types and constants for the deadline-sorted task scheduler
// Holds the operation and status codes, the controller state type and the
// control bundle that drives the row of queue cells.
// ----------------------------------------------------------------------------
package sdts_pkg;

	localparam int DEF_QUEUE_DEPTH = 32;
	localparam int DEF_TASK_COUNT  = 32;

	localparam int ID_W    = 5;
	localparam int TIME_W  = 32;
	localparam int COUNT_W = 6;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_TICK  = 2'd1,
		OP_DONE  = 2'd2,
		OP_ABORT = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_NONE       = 3'd0,
		ST_QUEUED     = 3'd1,
		ST_DUPLICATE  = 3'd2,
		ST_FULL       = 3'd3,
		ST_DISPATCHED = 3'd4,
		ST_DROPPED    = 3'd5
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	// per-cycle command to every cell of the queue
	typedef struct packed {
		logic insert;
		logic pop;
	} cell_ctrl_t;

endpackage

### design/deadline_sorted_task_scheduler_unit.sv
// ----------------------------------------------------------------------------
// deadline_sorted_task_scheduler_unit: deadline-sorted timer queue
// Queues task ids by start time, dispatches due tasks on millisecond ticks.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive operation, task_id, delay, interval and repeat_req
//   with start high; the request is taken at an edge where busy is low.
//   Result channel: status, out_task and queued_count are shown for exactly
//   one cycle with result_valid high. Every request gives one result. The
//   receiver cannot stall; a result not taken in its cycle is gone.
//   Configuration: cfg_we writes cfg_data[0] into the enable bit; write it
//   only while no request is in flight.
//   Timing: busy is high for one cycle after acceptance, while the cell row
//   does the insert or pop in parallel; result_valid rises the cycle after.
//   A new request can be taken in the result cycle. The critical path is the
//   start-time add feeding the compare in every cell.
//   Reset: clears the entry count, time, enable and the per-task queued,
//   repeat and abort bits. Slot contents and stored intervals are unknown
//   until written and are never read before that.
// ----------------------------------------------------------------------------
module deadline_sorted_task_scheduler_unit
	import sdts_pkg::*;
#(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int TASK_COUNT  = DEF_TASK_COUNT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_data,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         operation,
	input  logic [ID_W-1:0]    task_id,
	input  logic [TIME_W-1:0]  delay,
	input  logic [TIME_W-1:0]  interval,
	input  logic               repeat_req,
	output logic               result_valid,
	output logic [2:0]         status,
	output logic [ID_W-1:0]    out_task,
	output logic [COUNT_W-1:0] queued_count
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int TW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
	localparam int RW = 9;

	state_t state_q, state_n;
	logic   accept, exec;

	logic                 enable_q;
	logic [CW-1:0]        count_q;
	logic [TIME_W-1:0]    now_q;
	logic [TASK_COUNT-1:0] queued_q, repeats_q, abort_q;

	op_t               op_q;
	logic [ID_W-1:0]   id_q;
	logic [TIME_W-1:0] delay_q, interval_q, period_rd_q;
	logic              rep_q;

	logic [TIME_W-1:0] period_mem [TASK_COUNT];

	logic [TW-1:0]     id_idx, head_idx;
	logic              id_ok, head_ok;
	logic [ID_W-1:0]   head_task;
	logic [TIME_W-1:0] head_start, now_inc, enq_start;
	logic              due, enq_req, pop_req;
	status_t           status_n, status_q;
	logic [ID_W-1:0]   task_n;
	logic [CW-1:0]     count_n;
	cell_ctrl_t        cell_ctrl;

	// controller next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE:  if (start) state_n = S_EXEC;
			S_EXEC:  state_n = S_IDLE;
			default: state_n = S_IDLE;
		endcase
	end

	// controller outputs
	always_comb begin
		busy = 1'b0;
		exec = 1'b0;
		case (state_q)
			S_EXEC: begin
				busy = 1'b1;
				exec = 1'b1;
			end
			default: ;
		endcase
	end

	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// capture the request
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= op_t'(operation);
			id_q       <= task_id;
			delay_q    <= delay;
			interval_q <= interval;
			rep_q      <= repeat_req;
		end
	end

	// stored repeat interval; read on acceptance, written on a queued add
	always_ff @(posedge clk) begin
		if (accept) begin
			period_rd_q <= period_mem[TW'(task_id)];
		end
		if (exec && enq_req && (op_q == OP_ADD)) begin
			period_mem[id_idx] <= interval_q;
		end
	end

	assign id_idx   = TW'(id_q);
	assign id_ok    = RW'(id_q) < RW'(TASK_COUNT);
	assign head_idx = TW'(head_task);
	assign head_ok  = RW'(head_task) < RW'(TASK_COUNT);

	assign now_inc   = now_q + 1'b1;
	assign due       = (count_q != '0) && (now_inc >= head_start);
	assign enq_start = now_q + ((op_q == OP_ADD) ? delay_q : period_rd_q);

	// decode the request against the current state
	always_comb begin
		enq_req  = 1'b0;
		pop_req  = 1'b0;
		status_n = ST_NONE;
		task_n   = '0;
		if (exec) begin
			case (op_q)
				OP_TICK: begin
					if (enable_q && due) begin
						pop_req = 1'b1;
						task_n  = head_task;
						if (head_ok && abort_q[head_idx]) begin
							status_n = ST_DROPPED;
						end else begin
							status_n = ST_DISPATCHED;
						end
					end
				end
				OP_ADD, OP_DONE: begin
					if (id_ok && ((op_q == OP_ADD) || repeats_q[id_idx])) begin
						task_n = id_q;
						if (queued_q[id_idx]) begin
							status_n = ST_DUPLICATE;
						end else if (count_q == CW'(QUEUE_DEPTH)) begin
							status_n = ST_FULL;
						end else begin
							status_n = ST_QUEUED;
							enq_req  = 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		count_n = count_q;
		if (enq_req) begin
			count_n = count_q + 1'b1;
		end else if (pop_req) begin
			count_n = count_q - 1'b1;
		end
	end

	assign cell_ctrl.insert = enq_req;
	assign cell_ctrl.pop    = pop_req;

	sdts_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.ctrl      (cell_ctrl),
		.count     (count_q),
		.new_task  (id_q),
		.new_start (enq_start),
		.head_task (head_task),
		.head_start(head_start)
	);

	// advance time, count and per-task flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b0;
			count_q   <= '0;
			now_q     <= '0;
			queued_q  <= '0;
			repeats_q <= '0;
			abort_q   <= '0;
		end else begin
			if (cfg_we) begin
				enable_q <= cfg_data;
			end
			if (exec) begin
				count_q <= count_n;
				if ((op_q == OP_TICK) && enable_q) begin
					now_q <= now_inc;
				end
				if (enq_req) begin
					queued_q[id_idx] <= 1'b1;
					if (op_q == OP_ADD) begin
						repeats_q[id_idx] <= rep_q;
						abort_q[id_idx]   <= 1'b0;
					end
				end
				if (pop_req && head_ok) begin
					queued_q[head_idx] <= 1'b0;
					abort_q[head_idx]  <= 1'b0;
				end
				if ((op_q == OP_ABORT) && id_ok) begin
					abort_q[id_idx] <= 1'b1;
				end
			end
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= exec;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (exec) begin
			status_q     <= status_n;
			out_task     <= task_n;
			queued_count <= COUNT_W'(count_n);
		end
	end

	assign status = status_q;

	// an accepted request is worked on in the next cycle
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted request not executed");

	// every executed request yields exactly one result
	a_exec_result: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> (result_valid && !busy))
		else $error("executed request gave no result");

	// the queue never holds more entries than it has cells
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("entry count beyond queue depth");

	// queued flags track the entries in the cell row
	a_queued_match: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(queued_q) == int'(count_q))
		else $error("queued flags disagree with entry count");

	// a result with no event names no task
	a_none_task: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (status_q == ST_NONE)) |-> (out_task == '0))
		else $error("empty result carries a task id");

endmodule

### design/sdts_cell.sv
// ----------------------------------------------------------------------------
// sdts_cell: one slot of the sorted queue
// Holds one task id and its start time. On insert it keeps its entry, takes
// the new entry or takes its left neighbor's; on pop it takes its right
// neighbor's entry.
// ----------------------------------------------------------------------------
module sdts_cell
	import sdts_pkg::*;
(
	input  logic              clk,
	input  cell_ctrl_t        ctrl,
	input  logic              occupied,
	input  logic              left_lt,
	input  logic [ID_W-1:0]   left_task,
	input  logic [TIME_W-1:0] left_start,
	input  logic [ID_W-1:0]   right_task,
	input  logic [TIME_W-1:0] right_start,
	input  logic [ID_W-1:0]   new_task,
	input  logic [TIME_W-1:0] new_start,
	output logic              lt,
	output logic [ID_W-1:0]   cell_task,
	output logic [TIME_W-1:0] cell_start
);

	logic [ID_W-1:0]   slot_task_q;
	logic [TIME_W-1:0] slot_start_q;

	// entry stays ahead of the new request
	assign lt = occupied && (slot_start_q < new_start);

	// shift right on insert, left on pop
	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			if (!lt) begin
				if (left_lt) begin
					slot_task_q  <= new_task;
					slot_start_q <= new_start;
				end else begin
					slot_task_q  <= left_task;
					slot_start_q <= left_start;
				end
			end
		end else if (ctrl.pop) begin
			slot_task_q  <= right_task;
			slot_start_q <= right_start;
		end
	end

	assign cell_task  = slot_task_q;
	assign cell_start = slot_start_q;

endmodule

### design/sdts_queue.sv
// ----------------------------------------------------------------------------
// sdts_queue: row of cells forming the deadline-sorted queue
// Cell 0 is the head. Occupancy of each cell follows from the entry count.
// ----------------------------------------------------------------------------
module sdts_queue
	import sdts_pkg::*;
#(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic              clk,
	input  cell_ctrl_t        ctrl,
	input  logic [CW-1:0]     count,
	input  logic [ID_W-1:0]   new_task,
	input  logic [TIME_W-1:0] new_start,
	output logic [ID_W-1:0]   head_task,
	output logic [TIME_W-1:0] head_start
);

	logic [ID_W-1:0]   task_w  [QUEUE_DEPTH];
	logic [TIME_W-1:0] start_w [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] lt_w;

	// build the row; ends get tied-off neighbors
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic              left_lt;
		logic [ID_W-1:0]   left_task;
		logic [TIME_W-1:0] left_start;
		logic [ID_W-1:0]   right_task;
		logic [TIME_W-1:0] right_start;

		if (i == 0) begin : g_first
			assign left_lt    = 1'b1;
			assign left_task  = new_task;
			assign left_start = new_start;
		end else begin : g_mid
			assign left_lt    = lt_w[i-1];
			assign left_task  = task_w[i-1];
			assign left_start = start_w[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign right_task  = task_w[i];
			assign right_start = start_w[i];
		end else begin : g_inner
			assign right_task  = task_w[i+1];
			assign right_start = start_w[i+1];
		end

		sdts_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.occupied   (CW'(i) < count),
			.left_lt    (left_lt),
			.left_task  (left_task),
			.left_start (left_start),
			.right_task (right_task),
			.right_start(right_start),
			.new_task   (new_task),
			.new_start  (new_start),
			.lt         (lt_w[i]),
			.cell_task  (task_w[i]),
			.cell_start (start_w[i])
		);
	end

	assign head_task  = task_w[0];
	assign head_start = start_w[0];

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the deadline-sorted task scheduler
// Drives add, tick, done and abort requests through the start/busy handshake
// and checks every result strobe against a local scheduler model. Directed
// cases come first: disabled ticks, ordering, wrap and abort. A fill-and-drain
// pass follows, then random traffic with random sender gaps.
// ----------------------------------------------------------------------------
module tb;
	import sdts_pkg::*;

	localparam int SLOTS        = DEF_QUEUE_DEPTH;
	localparam int TASKS        = DEF_TASK_COUNT;
	localparam int STALL_LIMIT  = 1000;
	localparam int PHASES       = 10;
	localparam int PHASE_ITEMS  = 155;
	localparam int RING         = 16;

	typedef struct packed {
		status_t            st;
		logic [ID_W-1:0]    id;
		logic [COUNT_W-1:0] count;
	} outcome_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic               cfg_data = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         operation = '0;
	logic [ID_W-1:0]    task_id = '0;
	logic [TIME_W-1:0]  delay = '0;
	logic [TIME_W-1:0]  interval = '0;
	logic               repeat_req = 1'b0;
	logic               result_valid;
	logic [2:0]         status;
	logic [ID_W-1:0]    out_task;
	logic [COUNT_W-1:0] queued_count;

	// scheduler model state
	logic [ID_W-1:0]   q_task [SLOTS];
	logic [TIME_W-1:0] q_due [SLOTS];
	int                q_len;
	logic [TIME_W-1:0] sim_ms;
	bit                is_queued [TASKS];
	bit                repeats [TASKS];
	bit                abort_mark [TASKS];
	logic [TIME_W-1:0] period [TASKS];
	bit                running;

	// expected results in request order
	outcome_t exp_ring [RING];
	int       exp_head = 0;
	int       exp_tail = 0;
	int       exp_level = 0;

	int       mismatches = 0;
	int       n_requests = 0;
	int       quiet_cycles = 0;
	int       deepest = 0;
	int       tally [8];
	int       gap_pct = 0;

	deadline_sorted_task_scheduler_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.task_id      (task_id),
		.delay        (delay),
		.interval     (interval),
		.repeat_req   (repeat_req),
		.result_valid (result_valid),
		.status       (status),
		.out_task     (out_task),
		.queued_count (queued_count)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	task automatic report_mismatch(string what, int unsigned got_val, int unsigned want_val);
		$display("MISMATCH %s: got %0d expected %0d (after %0d requests)",
			what, got_val, want_val, n_requests);
		mismatches++;
	endtask

	// insert ahead of the first entry due at or after the new start
	function automatic status_t enqueue_task(logic [ID_W-1:0] id, logic [TIME_W-1:0] wait_ms);
		logic [TIME_W-1:0] due;
		int pos;
		if (is_queued[id])
			return ST_DUPLICATE;
		if (q_len >= SLOTS)
			return ST_FULL;
		due = sim_ms + wait_ms;
		pos = 0;
		while (pos < q_len && q_due[pos] < due)
			pos++;
		for (int k = q_len; k > pos; k--) begin
			q_task[k] = q_task[k-1];
			q_due[k]  = q_due[k-1];
		end
		q_task[pos] = id;
		q_due[pos]  = due;
		q_len++;
		is_queued[id] = 1'b1;
		return ST_QUEUED;
	endfunction

	// work out the result of one request and update the model
	function automatic outcome_t scheduler_outcome(op_t op, logic [ID_W-1:0] id,
			logic [TIME_W-1:0] wait_ms, logic [TIME_W-1:0] every, logic rep);
		outcome_t r;
		r.st = ST_NONE;
		r.id = '0;
		case (op)
			OP_TICK: begin
				if (running) begin
					sim_ms++;
					if (q_len > 0 && sim_ms >= q_due[0]) begin
						r.id = q_task[0];
						for (int k = 1; k < q_len; k++) begin
							q_task[k-1] = q_task[k];
							q_due[k-1]  = q_due[k];
						end
						q_len--;
						is_queued[r.id] = 1'b0;
						if (abort_mark[r.id]) begin
							abort_mark[r.id] = 1'b0;
							r.st = ST_DROPPED;
						end else begin
							r.st = ST_DISPATCHED;
						end
					end
				end
			end
			OP_ADD: begin
				r.st = enqueue_task(id, wait_ms);
				r.id = id;
				if (r.st == ST_QUEUED) begin
					period[id]     = every;
					repeats[id]    = rep;
					abort_mark[id] = 1'b0;
				end
			end
			OP_DONE: begin
				if (repeats[id]) begin
					r.st = enqueue_task(id, period[id]);
					r.id = id;
				end
			end
			default: begin
				abort_mark[id] = 1'b1;
			end
		endcase
		r.count = COUNT_W'(q_len);
		return r;
	endfunction

	// check results, track config writes and predict each accepted request
	always @(posedge clk) begin
		outcome_t want;
		if (!arst_n) begin
			q_len   = 0;
			sim_ms  = '0;
			running = 1'b0;
			for (int k = 0; k < TASKS; k++) begin
				is_queued[k]  = 1'b0;
				repeats[k]    = 1'b0;
				abort_mark[k] = 1'b0;
			end
		end else begin
			if (result_valid) begin
				if (exp_level == 0) begin
					report_mismatch("result with no request pending", status, 0);
				end else begin
					want = exp_ring[exp_head];
					exp_head = (exp_head + 1) % RING;
					exp_level--;
					if (status !== want.st)
						report_mismatch("status", status, want.st);
					if (out_task !== want.id)
						report_mismatch("out_task", out_task, want.id);
					if (queued_count !== want.count)
						report_mismatch("queued_count", queued_count, want.count);
				end
			end
			if (cfg_we)
				running = cfg_data;
			if (start && !busy) begin
				want = scheduler_outcome(op_t'(operation), task_id, delay, interval,
					repeat_req);
				exp_ring[exp_tail] = want;
				exp_tail = (exp_tail + 1) % RING;
				exp_level++;
				tally[int'(want.st)]++;
				n_requests++;
				if (q_len > deepest)
					deepest = q_len;
			end
			if (result_valid || (start && !busy))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	// end the run when nothing moves for too long
	initial begin
		while (quiet_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("timeout: nothing accepted for %0d cycles", STALL_LIMIT);
		$display("deadline_sorted_task_scheduler_unit test failed");
		$finish;
	end

	// present one request and hold it until the block takes it
	task automatic send_request(op_t op, logic [ID_W-1:0] id, logic [TIME_W-1:0] wait_ms,
			logic [TIME_W-1:0] every, logic rep);
		operation  <= op;
		task_id    <= id;
		delay      <= wait_ms;
		interval   <= every;
		repeat_req <= rep;
		start      <= 1'b1;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
	endtask

	// send with a random sender gap in front
	task automatic issue(op_t op, logic [ID_W-1:0] id, logic [TIME_W-1:0] wait_ms,
			logic [TIME_W-1:0] every, logic rep);
		if ($urandom_range(0, 99) < gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 13))
				@(posedge clk);
		end
		send_request(op, id, wait_ms, every, rep);
	endtask

	// drop start and wait until every request has its result
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (exp_level != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
	endtask

	task automatic set_enable(bit value);
		settle();
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we   <= 1'b0;
	endtask

	// ticks while disabled leave time frozen
	task automatic test_disabled();
		gap_pct = 30;
		issue(OP_TICK, 0, 0, 0, 0);
		issue(OP_ADD, 3, 0, 0, 0);
		issue(OP_TICK, 0, 0, 0, 0);
		issue(OP_ABORT, 3, 0, 0, 0);
		issue(OP_DONE, 3, 0, 0, 0);
		issue(OP_TICK, 0, 0, 0, 0);
	endtask

	// ordering, ties, start wrap, repeat and abort handling
	task automatic test_ordering();
		set_enable(1'b1);
		issue(OP_TICK, 0, 0, 0, 0);
		issue(OP_ADD, 5, 0, 32'hFFFF_FFFF, 1);
		issue(OP_ADD, 5, 7, 0, 0);
		issue(OP_ADD, 6, 0, 0, 0);
		issue(OP_ADD, 7, 32'hFFFF_FFFF, 0, 1);
		issue(OP_ADD, 31, 2, 1, 1);
		issue(OP_ADD, 0, 32'h8000_0000, 0, 0);
		issue(OP_ABORT, 0, 0, 0, 0);
		issue(OP_ABORT, 6, 0, 0, 0);
		issue(OP_TICK, 0, 0, 0, 0);
		issue(OP_TICK, 0, 0, 0, 0);
		issue(OP_DONE, 7, 0, 0, 0);
		issue(OP_DONE, 5, 0, 0, 0);
		repeat (4)
			issue(OP_TICK, 0, 0, 0, 0);
		issue(OP_DONE, 6, 0, 0, 0);
		issue(OP_DONE, 5, 0, 0, 0);
		issue(OP_TICK, 0, 0, 0, 0);
		issue(OP_ABORT, 9, 0, 0, 0);
		issue(OP_ADD, 9, 1, 32'hFFFF_FFFF, 0);
		issue(OP_TICK, 0, 0, 0, 0);
		issue(OP_TICK, 0, 0, 0, 0);
	endtask

	// fill every slot, refuse extra adds, freeze time, then drain by ticks
	task automatic test_fill_and_drain();
		gap_pct = 15;
		for (int id = 0; id < TASKS; id++)
			issue(OP_ADD, ID_W'(id), TIME_W'(20 + $urandom_range(0, 40)), $urandom,
				1'($urandom_range(0, 1)));
		issue(OP_ADD, 12, 0, 0, 1);
		issue(OP_DONE, 31, 0, 0, 0);
		for (int k = 0; k < 6; k++)
			issue(OP_ABORT, ID_W'($urandom_range(0, TASKS - 1)), 0, 0, 0);
		set_enable(1'b0);
		repeat (3)
			issue(OP_TICK, 0, 0, 0, 0);
		set_enable(1'b1);
		repeat (100)
			issue(OP_TICK, 0, 0, 0, 0);
	endtask

	function automatic logic [TIME_W-1:0] pick_time();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			return $urandom_range(0, 12);
		if (pick < 82)
			return $urandom_range(13, 100);
		if (pick < 97)
			return 32'hFFFF_FFFF - $urandom_range(0, 40);
		return $urandom;
	endfunction

	// mixed traffic, mostly on a small pool of tasks so repeats and aborts meet
	task automatic test_random_traffic();
		int unsigned pick;
		logic [ID_W-1:0] id;
		for (int phase = 0; phase < PHASES; phase++) begin
			set_enable(phase != 3);
			gap_pct = (phase >= PHASES - 2) ? 0 : (phase % 3) * 20;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(0, 99);
				id = ($urandom_range(0, 2) != 0) ? ID_W'($urandom_range(0, 7))
					: ID_W'($urandom_range(0, 31));
				if (pick < 30)
					issue(OP_ADD, id, pick_time(), pick_time(), $urandom_range(0, 9) < 6);
				else if (pick < 65)
					issue(OP_TICK, ID_W'($urandom), $urandom, $urandom,
						1'($urandom_range(0, 1)));
				else if (pick < 83)
					issue(OP_DONE, id, $urandom, $urandom, 1'($urandom_range(0, 1)));
				else
					issue(OP_ABORT, id, $urandom, $urandom, 1'($urandom_range(0, 1)));
			end
			// after phase 5, hold off until all results are back
			if (phase == 5)
				settle();
		end
	endtask

	initial begin
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_disabled();
		test_ordering();
		test_fill_and_drain();
		test_random_traffic();
		settle();
		$display("covered %0d requests: %0d queued, %0d duplicates, %0d dispatched, %0d dropped",
			n_requests, tally[ST_QUEUED], tally[ST_DUPLICATE], tally[ST_DISPATCHED],
			tally[ST_DROPPED]);
		$display("deepest queue %0d entries, %0d mismatches", deepest, mismatches);
		if (mismatches == 0 && exp_level == 0)
			$display("deadline_sorted_task_scheduler_unit test passed");
		else
			$display("deadline_sorted_task_scheduler_unit test failed");
		$finish;
	end

endmodule

### files.f
design/sdts_pkg.sv
design/sdts_cell.sv
design/sdts_queue.sv
design/deadline_sorted_task_scheduler_unit.sv
bench/tb.sv
